// ----- src/mda_pkg.sv -----
// shared types and constants for the multiply / divide / accumulate unit
// no dependencies
package mda_pkg;

    localparam logic [15:0] ADDR_CTRL    = 16'h2250;
    localparam logic [15:0] ADDR_A_LO    = 16'h2251;
    localparam logic [15:0] ADDR_A_HI    = 16'h2252;
    localparam logic [15:0] ADDR_B_LO    = 16'h2253;
    localparam logic [15:0] ADDR_B_HI    = 16'h2254;
    localparam logic [15:0] ADDR_RES_LO  = 16'h2306;
    localparam logic [15:0] ADDR_RES_HI  = 16'h230a;
    localparam logic [15:0] ADDR_OVF     = 16'h230b;

    localparam logic        OP_READ      = 1'b0;
    localparam logic        OP_WRITE     = 1'b1;

    localparam int unsigned CTRL_ACC_BIT = 1;
    localparam int unsigned CTRL_DIV_BIT = 0;

    // one radix-2 step per operand bit
    localparam int unsigned STEP_COUNT   = 16;
    localparam int unsigned CNT_BITS     = $clog2(STEP_COUNT);

    typedef struct packed {
        logic take;     // bus transaction accepted this cycle
        logic step;     // one iteration of the shift/add or shift/subtract unit
        logic finish;   // write back the operation result
    } mda_cmd_t;

    typedef struct packed {
        logic start_req;    // current bus transaction starts an operation
    } mda_sts_t;

endpackage

// ----- src/mda_ctrl.sv -----
// controller state machine: bus handshake, output valid, iteration count
// depends on mda_pkg
module mda_ctrl
    import mda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  mda_sts_t sts,
    output mda_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                take;

    // output register frees up in the same cycle its transaction leaves
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign take     = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    assign cmd.take   = take;
    assign cmd.step   = (state_reg == ST_RUN);
    assign cmd.finish = (state_reg == ST_FINISH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (take)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (take && sts.start_req)
                        state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(STEP_COUNT - 1))
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/mda_dp.sv -----
// datapath: bus registers, radix-2 multiply / divide unit, result and read byte
// depends on mda_pkg
module mda_dp
    import mda_pkg::*;
#(
    parameter int unsigned RESULT_BITS = 40
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  mda_cmd_t   cmd,
    output mda_sts_t   sts,
    input  logic       opcode,
    input  logic [15:0] address,
    input  logic [7:0] write_data,
    output logic [7:0] read_data
);

    localparam logic [63:0] RES_MASK = {64{1'b1}} >> (64 - RESULT_BITS);

    logic [15:0]            operand_a_reg;
    logic [15:0]            operand_b_reg;
    logic [RESULT_BITS-1:0] result_reg;
    logic                   ovf_reg;
    logic                   acc_mode_reg;
    logic                   div_mode_reg;
    logic [7:0]             read_data_reg;

    // iteration registers: hi holds partial product / remainder
    logic [16:0]            hi_reg;
    logic [15:0]            lo_reg;
    logic [15:0]            mag_reg;
    logic                   neg_reg;

    logic                   is_mul;
    logic [15:0]            b_new;
    logic [15:0]            a_abs;
    logic [15:0]            b_abs;
    logic [16:0]            mul_sum;
    logic [16:0]            div_trial;
    logic [17:0]            div_diff;
    logic [31:0]            prod_mag;
    logic [31:0]            prod_s;
    logic [63:0]            prod64;
    logic [63:0]            acc_sum;
    logic [15:0]            quot;
    logic [15:0]            rem;
    logic [63:0]            res_wide;
    logic [15:0]            byte_off;
    logic [7:0]             rd_byte;

    assign sts.start_req = (opcode == OP_WRITE) && (address == ADDR_B_HI);
    assign is_mul        = acc_mode_reg || !div_mode_reg;

    assign b_new = {write_data, operand_b_reg[7:0]};
    assign a_abs = operand_a_reg[15] ? (16'd0 - operand_a_reg) : operand_a_reg;
    assign b_abs = b_new[15] ? (16'd0 - b_new) : b_new;

    // multiply step: add multiplicand on low bit, shift right
    assign mul_sum = {1'b0, hi_reg[15:0]} + (lo_reg[0] ? {1'b0, mag_reg} : 17'd0);

    // restoring divide step
    assign div_trial = {hi_reg[15:0], lo_reg[15]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, mag_reg};

    assign prod_mag = {hi_reg[15:0], lo_reg};
    assign prod_s   = neg_reg ? (32'd0 - prod_mag) : prod_mag;
    assign prod64   = {{32{prod_s[31]}}, prod_s};
    assign acc_sum  = 64'(result_reg) + prod64;

    assign quot = neg_reg ? (16'd0 - lo_reg) : lo_reg;
    assign rem  = neg_reg ? (16'd0 - hi_reg[15:0]) : hi_reg[15:0];

    assign res_wide = 64'(result_reg);
    assign byte_off = address - ADDR_RES_LO;

    always_comb
    begin
        rd_byte = 8'd0;
        if (address >= ADDR_RES_LO && address <= ADDR_RES_HI)
            rd_byte = res_wide[{byte_off[2:0], 3'b000} +: 8];
        else if (address == ADDR_OVF)
            rd_byte = {ovf_reg, 7'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_a_reg <= '0;
            operand_b_reg <= '0;
            result_reg    <= '0;
            ovf_reg       <= 1'b0;
            acc_mode_reg  <= 1'b0;
            div_mode_reg  <= 1'b0;
            read_data_reg <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                read_data_reg <= (opcode == OP_WRITE) ? 8'd0 : rd_byte;
                if (opcode == OP_WRITE)
                begin
                    case (address)
                        ADDR_CTRL:
                        begin
                            acc_mode_reg <= write_data[CTRL_ACC_BIT];
                            div_mode_reg <= write_data[CTRL_DIV_BIT];
                            if (write_data[CTRL_ACC_BIT])
                                result_reg <= '0;
                        end
                        ADDR_A_LO: operand_a_reg[7:0]  <= write_data;
                        ADDR_A_HI: operand_a_reg[15:8] <= write_data;
                        ADDR_B_LO: operand_b_reg[7:0]  <= write_data;
                        ADDR_B_HI:
                        begin
                            operand_b_reg <= b_new;
                            hi_reg        <= '0;
                            if (is_mul)
                            begin
                                lo_reg  <= b_abs;
                                mag_reg <= a_abs;
                                neg_reg <= operand_a_reg[15] ^ b_new[15];
                            end
                            else
                            begin
                                lo_reg  <= a_abs;
                                mag_reg <= b_new;
                                neg_reg <= operand_a_reg[15];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (cmd.step)
            begin
                if (is_mul)
                begin
                    hi_reg <= {1'b0, mul_sum[16:1]};
                    lo_reg <= {mul_sum[0], lo_reg[15:1]};
                end
                else
                begin
                    hi_reg <= div_diff[17] ? div_trial : div_diff[16:0];
                    lo_reg <= {lo_reg[14:0], !div_diff[17]};
                end
            end

            if (cmd.finish)
            begin
                if (acc_mode_reg)
                begin
                    ovf_reg       <= |(acc_sum & ~RES_MASK);
                    result_reg    <= RESULT_BITS'(acc_sum);
                    operand_a_reg <= '0;
                end
                else if (!div_mode_reg)
                begin
                    result_reg    <= RESULT_BITS'(prod64);
                    operand_b_reg <= '0;
                end
                else
                begin
                    if (mag_reg == 16'd0)
                        result_reg <= '0;
                    else
                        result_reg <= RESULT_BITS'({rem, quot});
                    operand_a_reg <= '0;
                    operand_b_reg <= '0;
                end
            end
        end
    end

    assign read_data = read_data_reg;

endmodule

// ----- src/mul_div_accumulate_unit.sv -----
// memory-mapped multiply / divide / multiply-accumulate unit, top level
// output: every bus transaction gives its byte in the cycle after it is accepted
// throughput: one transaction per cycle while out_stall is low, except a write of the
// operand b high byte, which stalls the next one through 16 radix-2 steps and a write-back
// reset: asynchronous active low, clears operands, result, overflow flag and modes
// depends on mda_pkg, mda_ctrl, mda_dp
module mul_div_accumulate_unit
    import mda_pkg::*;
#(
    parameter int unsigned RESULT_BITS = 40
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data
);

    mda_cmd_t cmd;
    mda_sts_t sts;

    mda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mda_dp #(
        .RESULT_BITS (RESULT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (opcode),
        .address    (address),
        .write_data (write_data),
        .read_data  (read_data)
    );

    // an operation start blocks the next transaction
    a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_WRITE && address == ADDR_B_HI |=> in_stall)
        else $error("operation start did not stall input");

    // every accepted transaction is presented on the output next cycle
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transaction not presented");

    // writes always return zero
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_WRITE |=> read_data == 8'd0)
        else $error("write returned nonzero data");

endmodule

// ----- verif/mul_div_accumulate_unit_test.sv -----
// self-checking testbench for mul_div_accumulate_unit: bus transactions in, read bytes out
// a scoreboard class predicts each byte, plain tasks drive random sequences with stalls
// depends on mda_pkg and mul_div_accumulate_unit
module mul_div_accumulate_unit_test
    import mda_pkg::*;
;

    localparam int          RES_W       = 40;
    localparam logic [63:0] RES_MASK    = {64{1'b1}} >> (64 - RES_W);
    localparam int          ITEM_TARGET = 1750;
    localparam int          QUIET_LIMIT = 4000;

    class mda_byte_checker;
        logic [15:0] op_a;
        logic [15:0] op_b;
        logic [63:0] res_val;
        logic        ovf_flag;
        logic        acc_mode;
        logic        div_mode;
        logic [7:0]  expected_bytes[$];
        int          errors;
        int          checked;

        function new();
            op_a     = '0;
            op_b     = '0;
            res_val  = '0;
            ovf_flag = 1'b0;
            acc_mode = 1'b0;
            div_mode = 1'b0;
            errors   = 0;
            checked  = 0;
        endfunction

        // write of the b high byte kicks off multiply, divide or accumulate
        function void start_op();
            logic signed [31:0] prod;
            logic [63:0]        prod64;
            logic [63:0]        sum;
            int                 num;
            int                 den;
            logic [31:0]        quo;
            logic [31:0]        rem;
            prod   = int'($signed(op_a)) * int'($signed(op_b));
            prod64 = {{32{prod[31]}}, prod};
            if (acc_mode)
            begin
                sum      = res_val + prod64;
                ovf_flag = |(sum & ~RES_MASK);
                res_val  = sum & RES_MASK;
                op_a     = '0;
            end
            else if (!div_mode)
            begin
                res_val = prod64 & RES_MASK;
                op_b    = '0;
            end
            else
            begin
                if (op_b == '0)
                    res_val = '0;
                else
                begin
                    num     = int'($signed(op_a));
                    den     = int'(op_b);
                    quo     = num / den;
                    rem     = num % den;
                    res_val = {32'd0, rem[15:0], quo[15:0]} & RES_MASK;
                end
                op_a = '0;
                op_b = '0;
            end
        endfunction

        function void note_access(logic op, logic [15:0] addr, logic [7:0] wdata);
            logic [7:0]  rd;
            logic [63:0] shifted;
            rd = 8'h00;
            if (op == OP_WRITE)
            begin
                case (addr)
                    ADDR_CTRL:
                    begin
                        acc_mode = wdata[CTRL_ACC_BIT];
                        div_mode = wdata[CTRL_DIV_BIT];
                        if (acc_mode)
                            res_val = '0;
                    end
                    ADDR_A_LO: op_a[7:0]  = wdata;
                    ADDR_A_HI: op_a[15:8] = wdata;
                    ADDR_B_LO: op_b[7:0]  = wdata;
                    ADDR_B_HI:
                    begin
                        op_b[15:8] = wdata;
                        start_op();
                    end
                    default: ;
                endcase
            end
            else if (addr >= ADDR_RES_LO && addr <= ADDR_RES_HI)
            begin
                shifted = res_val >> (8 * (addr - ADDR_RES_LO));
                rd      = shifted[7:0];
            end
            else if (addr == ADDR_OVF)
                rd = ovf_flag ? 8'h80 : 8'h00;
            expected_bytes.push_back(rd);
        endfunction

        task report_mismatch(string what, logic [7:0] want, logic [7:0] got);
            $display("mismatch at result %0d: %s, expected 0x%02h got 0x%02h",
                     checked, what, want, got);
            errors++;
        endtask

        task check_result(logic [7:0] got);
            logic [7:0] want;
            checked++;
            if (expected_bytes.size() == 0)
                report_mismatch("read_data with no transaction pending", 8'h00, got);
            else
            begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report_mismatch("read_data", want, got);
            end
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        opcode     = OP_READ;
    logic [15:0] address    = '0;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  read_data;

    mda_byte_checker sb;
    int              issued      = 0;
    int              quiet_count = 0;
    int              pace_left   = 0;
    bit              no_gaps     = 1'b0;
    bit              hold_req    = 1'b0;

    mul_div_accumulate_unit #(
        .RESULT_BITS (RES_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // holds the transaction until accepted; returns at the accepting edge
    task automatic send_access(logic op, logic [15:0] addr, logic [7:0] wdata);
        in_valid   <= 1'b1;
        opcode     <= op;
        address    <= addr;
        write_data <= wdata;
        do @(posedge clk); while (in_stall);
        // writes to unmapped addresses do nothing and are not counted
        if (!(op == OP_WRITE && (addr < ADDR_CTRL || addr > ADDR_B_HI)))
            issued++;
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // random gap, with stretches of back-to-back traffic, then the transaction
    task automatic offer_access(logic op, logic [15:0] addr, logic [7:0] wdata);
        int r;
        if (pace_left == 0)
        begin
            pace_left = $urandom_range(20, 120);
            no_gaps   = ($urandom_range(0, 3) == 0);
        end
        pace_left--;
        r = $urandom_range(0, 99);
        if (!no_gaps)
        begin
            if (r < 55)
                ;
            else if (r < 88)
                idle_sender($urandom_range(1, 3));
            else if (r < 97)
                idle_sender($urandom_range(4, 10));
            else
                idle_sender($urandom_range(20, 50));
        end
        send_access(op, addr, wdata);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h7fff;
            3:       return 16'h8000;
            4:       return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    // optional mode and operand writes, start, then a few result or overflow flag reads
    task automatic run_op_sequence();
        logic [15:0] a;
        logic [15:0] b;
        int          nreads;
        a = pick_operand();
        b = pick_operand();
        if ($urandom_range(0, 1) == 1)
            offer_access(OP_WRITE, ADDR_CTRL, 8'($urandom()));
        if ($urandom_range(0, 9) != 0)
            offer_access(OP_WRITE, ADDR_A_LO, a[7:0]);
        if ($urandom_range(0, 9) != 0)
            offer_access(OP_WRITE, ADDR_A_HI, a[15:8]);
        if ($urandom_range(0, 9) != 0)
            offer_access(OP_WRITE, ADDR_B_LO, b[7:0]);
        offer_access(OP_WRITE, ADDR_B_HI, b[15:8]);
        nreads = $urandom_range(1, 6);
        repeat (nreads)
            offer_access(OP_READ, 16'(ADDR_RES_LO + $urandom_range(0, 5)), 8'($urandom()));
    endtask

    initial
    begin
        int          r;
        bit          held_once;
        bit          drained_once;
        logic [15:0] noise_addr;
        held_once    = 1'b0;
        drained_once = 1'b0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: overflow flag after reset, data ignored on a read
        send_access(OP_READ, ADDR_OVF, 8'hff);
        // multiply of the largest positive by the most negative operand
        send_access(OP_WRITE, ADDR_CTRL, 8'h00);
        send_access(OP_WRITE, ADDR_A_LO, 8'hff);
        send_access(OP_WRITE, ADDR_A_HI, 8'h7f);
        send_access(OP_WRITE, ADDR_B_LO, 8'h00);
        send_access(OP_WRITE, ADDR_B_HI, 8'h80);
        send_access(OP_READ, ADDR_RES_HI, 8'h00);
        // signed dividend over unsigned divisor, negative remainder
        send_access(OP_WRITE, ADDR_CTRL, 8'h01);
        send_access(OP_WRITE, ADDR_A_LO, 8'h00);
        send_access(OP_WRITE, ADDR_A_HI, 8'h80);
        send_access(OP_WRITE, ADDR_B_LO, 8'h07);
        send_access(OP_WRITE, ADDR_B_HI, 8'h00);
        send_access(OP_READ, ADDR_RES_LO + 16'd2, 8'h00);
        // divide by zero, operands were cleared by the previous divide
        send_access(OP_WRITE, ADDR_A_HI, 8'h12);
        send_access(OP_WRITE, ADDR_B_HI, 8'h00);
        send_access(OP_READ, ADDR_RES_LO, 8'h00);
        // accumulate wins over divide; a negative product sets the overflow flag
        send_access(OP_WRITE, ADDR_CTRL, 8'h03);
        send_access(OP_WRITE, ADDR_A_LO, 8'hff);
        send_access(OP_WRITE, ADDR_A_HI, 8'hff);
        send_access(OP_WRITE, ADDR_B_LO, 8'h01);
        send_access(OP_WRITE, ADDR_B_HI, 8'h00);
        send_access(OP_READ, ADDR_OVF, 8'h00);
        send_access(OP_READ, ADDR_RES_HI, 8'h00);
        // a was cleared, so this adds zero and clears the flag
        send_access(OP_WRITE, ADDR_B_HI, 8'h00);
        send_access(OP_READ, ADDR_OVF, 8'h00);
        // unmapped addresses
        send_access(OP_WRITE, 16'hffff, 8'hff);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_READ, ADDR_OVF + 16'd1, 8'h00);

        while (issued < ITEM_TARGET)
        begin
            if (!held_once && issued >= 600)
            begin
                // receiver holds off while transactions keep coming back to back
                held_once = 1'b1;
                hold_req  = 1'b1;
                repeat (40)
                    send_access(OP_READ, 16'(ADDR_RES_LO + $urandom_range(0, 5)),
                                8'($urandom()));
            end
            if ((!drained_once && issued >= 1200) || $urandom_range(0, 99) == 0)
            begin
                drained_once = 1'b1;
                drain_results();
            end
            r = $urandom_range(0, 99);
            noise_addr = ($urandom_range(0, 1) == 1) ? 16'($urandom())
                                                      : 16'(16'h2248 + $urandom_range(0, 200));
            if (r < 70)
                run_op_sequence();
            else if (r < 85)
                offer_access(OP_READ, noise_addr, 8'($urandom()));
            else
                offer_access(OP_WRITE, noise_addr, 8'($urandom()));
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver: phases of different stall density, short bursts, one long hold-off
    initial
    begin
        int hold_left;
        int phase_left;
        int stall_pct;
        int r;
        hold_left  = 0;
        phase_left = 0;
        stall_pct  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 100;
                out_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(50, 300);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 10;
                        2:       stall_pct = 30;
                        default: stall_pct = 60;
                    endcase
                end
                phase_left--;
                r = $urandom_range(0, 199);
                if (stall_pct != 0 && r == 0)
                begin
                    hold_left = $urandom_range(15, 40);
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= (r % 100) < stall_pct;
            end
        end
    end

    // check the result first: a result never belongs to the transaction taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(read_data);
            if (in_valid && !in_stall)
                sb.note_access(opcode, address, write_data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
